### rtl/colour_sensor_sequencer_classifier_defines.svh
// Assertion macros shared by the colour sensor sequencer RTL
`ifndef COLOUR_SENSOR_SEQUENCER_CLASSIFIER_DEFINES_SVH
`define COLOUR_SENSOR_SEQUENCER_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csc assertion failed");
// next-cycle implication, held off during reset
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/csc_pkg.sv
// Types, constants and helpers for the colour sensor sequencer
package csc_pkg;

    // pulse count width and the mask applied to incoming counts
    localparam int COUNT_BITS = 16;
    localparam int CNT_W      = 16;
    localparam int BOUND_W    = 48;
    localparam logic [CNT_W-1:0] CNT_MASK = CNT_W'((33'd1 << COUNT_BITS) - 33'd1);

    // filter select pin codes, bit0 first pin
    localparam logic [1:0] PINS_RED   = 2'd0;
    localparam logic [1:0] PINS_GREEN = 2'd3;
    localparam logic [1:0] PINS_BLUE  = 2'd1;

    // input item kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        COL_WHITE   = 2'd0,
        COL_YELLOW  = 2'd1,
        COL_BLUE    = 2'd2,
        COL_UNKNOWN = 2'd3
    } t_colour;

    typedef enum logic [2:0] {
        CFG_WHITE_LOW   = 3'd0,
        CFG_WHITE_HIGH  = 3'd1,
        CFG_YELLOW_LOW  = 3'd2,
        CFG_YELLOW_HIGH = 3'd3,
        CFG_BLUE_LOW    = 3'd4,
        CFG_BLUE_HIGH   = 3'd5
    } t_cfg_idx;

    // measurement sequencer, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ARM   = 5'b00010,
        PH_RED   = 5'b00100,
        PH_GREEN = 5'b01000,
        PH_BLUE  = 5'b10000
    } t_phase;

    // window bounds: red 15..0, green 31..16, blue 47..32
    typedef struct packed {
        logic [BOUND_W-1:0] white_low;
        logic [BOUND_W-1:0] white_high;
        logic [BOUND_W-1:0] yellow_low;
        logic [BOUND_W-1:0] yellow_high;
        logic [BOUND_W-1:0] blue_low;
        logic [BOUND_W-1:0] blue_high;
    } t_windows;

    // result item, filter_pins in the lowest bits
    typedef struct packed {
        t_colour    colour;
        logic       done_res;
        logic       clear_counter;
        logic [1:0] filter_pins;
    } t_result;

    // all three channels inside their inclusive bounds
    function automatic logic window_hit(
        input logic [BOUND_W-1:0] lo,
        input logic [BOUND_W-1:0] hi,
        input logic [CNT_W-1:0]   r,
        input logic [CNT_W-1:0]   g,
        input logic [CNT_W-1:0]   b
    );
        logic hit_r, hit_g, hit_b;
        hit_r = (r >= lo[15:0])  && (r <= hi[15:0]);
        hit_g = (g >= lo[31:16]) && (g <= hi[31:16]);
        hit_b = (b >= lo[47:32]) && (b <= hi[47:32]);
        return hit_r && hit_g && hit_b;
    endfunction

endpackage

### rtl/colour_sensor_sequencer_classifier.sv
// Colour sensor sequencer and classifier, top level
//
// Input stream: s_axis_tuser[0] is the item kind (0 start, 1 timer tick),
// s_axis_tdata[15:0] the sensor pulse count. Every accepted item gives one
// result on the output stream: filter pins, counter clear, done flag and
// colour code. A start arms a measurement; the next four ticks step through
// arm, red, green and blue, and the blue tick classifies the counts against
// the white, yellow and blue windows. Ticks while idle and starts while busy
// give a result that only shows the current pins.
// Window bounds come in over the configuration channel, which is always
// ready; write it only while no result is outstanding.
// The result is registered. One item per cycle is sustained while the skid
// register is empty: the sequencer state and classifier update in the
// accept cycle, the result lands in an output register, and a one-entry skid
// register absorbs a stall so s_axis_tready never waits on m_axis_tready.
// s_axis_tready drops only while the skid register is full.
// Reset sets the windows to empty (every result unknown), idles the
// sequencer, selects red and empties the output and skid registers.
`include "colour_sensor_sequencer_classifier_defines.svh"
module colour_sensor_sequencer_classifier
    import csc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [15:0] count
    input  logic [0:0]    s_axis_tuser,   // [0] func
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // [1:0] filter_pins, [2] clear_counter,
                                          // [3] done_res, [5:4] colour, [7:6] zero
    // configuration writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [47:0]   i_cfg_data
);

    t_windows         r_win;
    t_phase           r_phase, n_phase;
    logic [1:0]       r_pins, n_pins;
    logic [CNT_W-1:0] r_red, n_red;
    logic [CNT_W-1:0] r_green, n_green;
    logic             r_out_valid;
    t_result          r_out_data;
    logic             r_skid_valid;
    t_result          r_skid_data;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] cnt;
    t_colour          class_colour;
    t_result          res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign cnt           = s_axis_tdata & CNT_MASK;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.white_low   <= '1;
            r_win.white_high  <= '0;
            r_win.yellow_low  <= '1;
            r_win.yellow_high <= '0;
            r_win.blue_low    <= '1;
            r_win.blue_high   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WHITE_LOW:   r_win.white_low   <= i_cfg_data;
                CFG_WHITE_HIGH:  r_win.white_high  <= i_cfg_data;
                CFG_YELLOW_LOW:  r_win.yellow_low  <= i_cfg_data;
                CFG_YELLOW_HIGH: r_win.yellow_high <= i_cfg_data;
                CFG_BLUE_LOW:    r_win.blue_low    <= i_cfg_data;
                CFG_BLUE_HIGH:   r_win.blue_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify against stored red/green and the incoming blue count
    csc_classify u_classify (
        .i_red    (r_red),
        .i_green  (r_green),
        .i_blue   (cnt),
        .i_win    (r_win),
        .o_colour (class_colour)
    );

    // sequencer next state and result for the item on the input
    always_comb begin
        n_phase           = r_phase;
        n_pins            = r_pins;
        n_red             = r_red;
        n_green           = r_green;
        res.clear_counter = 1'b0;
        res.done_res      = 1'b0;
        res.colour        = COL_WHITE;
        if (s_axis_tuser[0] == FUNC_START) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_ARM;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_ARM: begin
                    res.clear_counter = 1'b1;
                    n_pins            = PINS_RED;
                    n_phase           = PH_RED;
                end
                PH_RED: begin
                    n_red             = cnt;
                    res.clear_counter = 1'b1;
                    n_pins            = PINS_GREEN;
                    n_phase           = PH_GREEN;
                end
                PH_GREEN: begin
                    n_green           = cnt;
                    res.clear_counter = 1'b1;
                    n_pins            = PINS_BLUE;
                    n_phase           = PH_BLUE;
                end
                PH_BLUE: begin
                    res.done_res = 1'b1;
                    res.colour   = class_colour;
                    n_phase      = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
        res.filter_pins = n_pins;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pins  <= PINS_RED;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_pins  <= n_pins;
        end
    end

    // stored counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
        end else if (in_xfer) begin
            r_red   <= n_red;
            r_green <= n_green;
        end
    end

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_xfer) begin
            r_out_valid  <= r_skid_valid || in_xfer;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            r_out_data <= r_skid_valid ? r_skid_data : res;
        end else if (in_xfer) begin
            r_skid_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data};

    // checks
    `CSC_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CSC_ASSERT_IMP(a_colour_zero_unless_done, i_clk, i_rst_n,
        r_out_valid && !r_out_data.done_res, r_out_data.colour == COL_WHITE)
    `CSC_ASSERT_IMP(a_no_clear_with_done, i_clk, i_rst_n,
        r_out_valid, !(r_out_data.done_res && r_out_data.clear_counter))
    `CSC_ASSERT_NEXT(a_blue_tick_idles, i_clk, i_rst_n,
        in_xfer && s_axis_tuser[0] == FUNC_TICK && r_phase == PH_BLUE, r_phase == PH_IDLE)

endmodule

### rtl/csc_classify.sv
// Window classifier: first matching window among white, yellow, blue
module csc_classify
    import csc_pkg::*;
(
    input  logic [CNT_W-1:0] i_red,
    input  logic [CNT_W-1:0] i_green,
    input  logic [CNT_W-1:0] i_blue,
    input  t_windows         i_win,
    output t_colour          o_colour
);

    logic hit_white, hit_yellow, hit_blue;

    // three parallel compare triples
    assign hit_white  = window_hit(i_win.white_low,  i_win.white_high,  i_red, i_green, i_blue);
    assign hit_yellow = window_hit(i_win.yellow_low, i_win.yellow_high, i_red, i_green, i_blue);
    assign hit_blue   = window_hit(i_win.blue_low,   i_win.blue_high,   i_red, i_green, i_blue);

    // priority: white wins over yellow over blue
    always_comb begin
        if (hit_white) begin
            o_colour = COL_WHITE;
        end else if (hit_yellow) begin
            o_colour = COL_YELLOW;
        end else if (hit_blue) begin
            o_colour = COL_BLUE;
        end else begin
            o_colour = COL_UNKNOWN;
        end
    end

endmodule

### bench/tb_colour_sensor_sequencer_classifier.sv
// Self-checking testbench for the colour sensor sequencer and classifier
`timescale 1ns / 1ps

module tb_colour_sensor_sequencer_classifier;
    import csc_pkg::*;

    localparam int HALF_PERIOD       = 10;
    localparam int RESET_CYCLES      = 9;
    localparam int SETTLE_CYCLES     = 4;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int ITEMS_PER_SETTING = 150;
    localparam int REPORT_LIMIT      = 10;
    localparam int IDLE_PCT          = 18;
    localparam int STRAY_START_PCT   = 10;

    // measurement steps as the sequencer walks them
    typedef enum logic [1:0] {
        STEP_ARM   = 2'd0,
        STEP_RED   = 2'd1,
        STEP_GREEN = 2'd2,
        STEP_BLUE  = 2'd3
    } t_step;

    // window programmes used by the random part
    typedef enum int {
        WIN_RANDOM = 0,
        WIN_NESTED = 1,
        WIN_OPEN   = 2,
        WIN_ZERO   = 3,
        WIN_EMPTY  = 4
    } t_win_setting;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] count
    logic [0:0]  s_axis_tuser  = '0;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [1:0] pins, [2] clear, [3] done, [5:4] colour
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [47:0] i_cfg_data    = '0;

    // sequencer model state, at its reset values
    logic [47:0] win_bounds [0:5] = '{48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF, 48'h0,
                                      48'hFFFF_FFFF_FFFF, 48'h0};
    logic        m_busy  = 1'b0;
    t_step       m_step  = STEP_ARM;
    logic [15:0] m_red   = '0;
    logic [15:0] m_green = '0;
    logic [1:0]  m_pins  = PINS_RED;

    t_result     pending_results [$];
    logic        gaps_on        = 1'b1;
    int          items_sent     = 0;
    int          ignored_items  = 0;
    int          cfg_writes     = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;
    int          colours_seen [0:3] = '{0, 0, 0, 0};
    int          cycle_count;

    colour_sensor_sequencer_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // all three lanes inside the window whose lower bound sits at lo_idx
    function automatic logic lanes_in(int lo_idx, logic [15:0] r, logic [15:0] g,
                                      logic [15:0] b);
        logic [47:0] rgb;
        logic [47:0] lo;
        logic [47:0] hi;
        rgb = {b, g, r};
        lo  = win_bounds[lo_idx];
        hi  = win_bounds[lo_idx + 1];
        for (int lane = 0; lane < 3; lane++) begin
            if (rgb[16*lane +: 16] < lo[16*lane +: 16] || rgb[16*lane +: 16] > hi[16*lane +: 16])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // windows tried in priority order
    function automatic t_colour classify(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        if (lanes_in(CFG_WHITE_LOW, r, g, b))
            return COL_WHITE;
        if (lanes_in(CFG_YELLOW_LOW, r, g, b))
            return COL_YELLOW;
        if (lanes_in(CFG_BLUE_LOW, r, g, b))
            return COL_BLUE;
        return COL_UNKNOWN;
    endfunction

    // advance the sequencer model by one accepted item, give the expected result
    function automatic t_result predict_item(logic func, logic [15:0] raw);
        t_result     res;
        logic [15:0] cnt;
        cnt = raw & CNT_MASK;
        res = '0;
        if (func == FUNC_START) begin
            if (!m_busy) begin
                m_busy = 1'b1;
                m_step = STEP_ARM;
            end else begin
                ignored_items++;
            end
        end else if (!m_busy) begin
            ignored_items++;
        end else begin
            case (m_step)
                STEP_ARM: begin
                    res.clear_counter = 1'b1;
                    m_pins = PINS_RED;
                    m_step = STEP_RED;
                end
                STEP_RED: begin
                    m_red = cnt;
                    res.clear_counter = 1'b1;
                    m_pins = PINS_GREEN;
                    m_step = STEP_GREEN;
                end
                STEP_GREEN: begin
                    m_green = cnt;
                    res.clear_counter = 1'b1;
                    m_pins = PINS_BLUE;
                    m_step = STEP_BLUE;
                end
                default: begin
                    res.colour   = classify(m_red, m_green, cnt);
                    res.done_res = 1'b1;
                    m_step = STEP_ARM;
                    m_busy = 1'b0;
                end
            endcase
        end
        res.filter_pins = m_pins;
        return res;
    endfunction

    // count for one lane, mostly inside the target colour's window
    function automatic logic [15:0] lane_pick(int colour_idx, int lane);
        logic [15:0] lo;
        logic [15:0] hi;
        int          roll;
        lo   = win_bounds[2*colour_idx][16*lane +: 16];
        hi   = win_bounds[2*colour_idx + 1][16*lane +: 16];
        roll = $urandom_range(99);
        if (lo <= hi && roll < 55)
            return 16'($urandom_range(hi, lo));
        if (lo <= hi && roll < 65)
            return (roll < 60) ? lo : hi;
        if (roll < 72)
            return 16'h0000;
        if (roll < 79)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(logic func, logic [15:0] cnt);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= cnt;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_results.push_back(predict_item(func, cnt));
        items_sent++;
    endtask

    // hold the input stream until every expected result has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; valid stays up for a following write
    task automatic cfg_write(t_cfg_idx idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        win_bounds[int'(idx)] = data;
        cfg_writes++;
    endtask

    // start, arm tick, then red, green and blue counts
    task automatic send_measurement(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                    int stray_pct, logic hold_mid);
        logic [15:0] counts [0:3];
        counts = '{16'($urandom), r, g, b};
        send_item(FUNC_START, 16'($urandom));
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(99) < stray_pct)
                send_item(FUNC_START, 16'($urandom));
            send_item(FUNC_TICK, counts[i]);
            if (hold_mid && i == 1)
                wait_drain();
        end
    endtask

    // load all six bound registers for one window programme
    task automatic program_windows(t_win_setting setting);
        logic [47:0] lo_word;
        logic [47:0] hi_word;
        int          lo_l;
        int          hi_l;
        int          half;
        for (int c = 0; c < 3; c++) begin
            for (int lane = 0; lane < 3; lane++) begin
                case (setting)
                    WIN_RANDOM: begin
                        lo_l = $urandom_range(65535);
                        hi_l = lo_l + $urandom_range(6000);
                        if (hi_l > 65535)
                            hi_l = 65535;
                    end
                    WIN_NESTED: begin
                        half = (c == 0) ? 500 : (c == 1) ? 4000 : 20000;
                        lo_l = 32768 - half;
                        hi_l = 32767 + half;
                    end
                    WIN_OPEN: begin
                        lo_l = 0;
                        hi_l = 65535;
                    end
                    WIN_ZERO: begin
                        lo_l = 0;
                        hi_l = 0;
                    end
                    default: begin
                        lo_l = 65535;
                        hi_l = 0;
                    end
                endcase
                lo_word[16*lane +: 16] = 16'(lo_l);
                hi_word[16*lane +: 16] = 16'(hi_l);
            end
            cfg_write(t_cfg_idx'(2*c), lo_word);
            cfg_write(t_cfg_idx'(2*c + 1), hi_word);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // idle tick, starts and a full measurement against the reset windows
    task automatic test_idle_cases();
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_START, 16'hFFFF);
        send_item(FUNC_START, 16'h0000);
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_TICK, 16'h8001);
        wait_drain();
    endtask

    // overlapping white and yellow windows, and a blue window at the extremes
    task automatic test_window_priority();
        cfg_write(CFG_WHITE_LOW,   {16'd1000, 16'd1000, 16'd1000});
        cfg_write(CFG_WHITE_HIGH,  {16'd2000, 16'd2000, 16'd2000});
        cfg_write(CFG_YELLOW_LOW,  {16'd0, 16'd1500, 16'd1500});
        cfg_write(CFG_YELLOW_HIGH, {16'd1800, 16'hFFFF, 16'hFFFF});
        cfg_write(CFG_BLUE_LOW,    {16'hFFFF, 16'h0000, 16'h0000});
        cfg_write(CFG_BLUE_HIGH,   {16'hFFFF, 16'hFFFF, 16'h0000});
        i_cfg_valid <= 1'b0;
        send_measurement(16'd1600, 16'd1600, 16'd1600, 0, 1'b0);
        send_measurement(16'd3000, 16'd3000, 16'd100, 0, 1'b0);
        send_measurement(16'h0000, 16'hFFFF, 16'hFFFF, 0, 1'b0);
    endtask

    // random measurements, noise and broken sequences under each programme
    task automatic test_random_settings();
        int          first_item;
        int          pick;
        int          target;
        logic        held;
        logic        hold;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        for (int s = WIN_RANDOM; s <= WIN_EMPTY; s++) begin
            wait_drain();
            program_windows(t_win_setting'(s));
            // the open-window programme runs without any idling
            gaps_on    = (s != WIN_OPEN);
            first_item = items_sent;
            held       = 1'b0;
            while (items_sent - first_item < ITEMS_PER_SETTING) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    target = $urandom_range(2);
                    r = lane_pick(target, 0);
                    g = lane_pick(target, 1);
                    b = lane_pick(target, 2);
                    hold = !held && (items_sent - first_item >= ITEMS_PER_SETTING / 2);
                    if (hold)
                        held = 1'b1;
                    send_measurement(r, g, b, STRAY_START_PCT, hold);
                end else if (pick < 90) begin
                    send_item(1'($urandom_range(1)), 16'($urandom));
                end else begin
                    send_item(FUNC_START, 16'($urandom));
                    repeat ($urandom_range(3)) send_item(FUNC_TICK, 16'($urandom));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // result side back-pressure
    always @(posedge i_clk)
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);

    // compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[5:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected: data %02h",
                             results_seen, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (want.done_res)
                    colours_seen[int'(want.colour)]++;
                if (got.filter_pins !== want.filter_pins
                    || got.clear_counter !== want.clear_counter
                    || got.done_res !== want.done_res
                    || got.colour !== want.colour) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"result %0d mismatch: expected pins %0d clear %0b done %0b",
                                  " colour %0d, got pins %0d clear %0b done %0b colour %0d"},
                                 results_seen, want.filter_pins, want.clear_counter,
                                 want.done_res, want.colour, got.filter_pins,
                                 got.clear_counter, got.done_res, got.colour);
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_cases();
        test_window_priority();
        test_random_settings();
        wait_drain();
        $display({"run covered %0d items (%0d ignored) and %0d register writes",
                  " over seven window sets"},
                 items_sent, ignored_items, cfg_writes);
        $display("classified white %0d, yellow %0d, blue %0d, unknown %0d; %0d mismatches",
                 colours_seen[0], colours_seen[1], colours_seen[2], colours_seen[3],
                 mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
